### sv/tgp_pkg.sv
// Shared constants and codes for the trigram predictor.
`timescale 1ns / 1ps

package tgp_pkg;

   localparam int SYMBOLS    = 11;
   localparam int COUNT_BITS = 16;

   localparam int SYM_W  = 4;
   localparam int FUNC_W = 2;
   localparam int THR_W  = 16;
   localparam int CONF_W = 16;
   localparam int Q_FRAC = 15;

   localparam int TRI_DEPTH  = SYMBOLS * SYMBOLS * SYMBOLS;
   localparam int PAIR_DEPTH = SYMBOLS * SYMBOLS;
   localparam int TRI_AW     = $clog2(TRI_DEPTH);
   localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
   localparam int SCAN_W     = $clog2(SYMBOLS + 1);
   localparam int DIV_W      = $clog2(Q_FRAC);
   localparam int OPW        = ((COUNT_BITS > THR_W) ? COUNT_BITS : THR_W) + 1;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [CONF_W-1:0]     Q_ONE   = CONF_W'(32768);

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 2;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PREDICT = 2'd2;

   // Register indexes
   localparam int CSR_AW = 1;
   localparam logic [CSR_AW-1:0] CSR_MIN_TRIPLE = 1'd0;
   localparam logic [CSR_AW-1:0] CSR_MIN_PAIR   = 1'd1;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] cnt);
      sat_inc = (cnt == CNT_MAX) ? cnt : cnt + COUNT_BITS'(1);
   endfunction

   function automatic logic sym_ok(input logic [SYM_W-1:0] s);
      sym_ok = (int'(s) < SYMBOLS);
   endfunction

endpackage

### sv/tgp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tgp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/trigram_predictor_with_backoff.sv
// Top level of the trigram predictor with bigram back-off.
//
// Usage: the req_ channel carries operations: tuser is the operation code
// (clear, add triple, predict), tdata the three symbols. Add and clear give
// no result; predict gives exactly one transfer on the rsp_ channel with the
// found and level flags in tuser and symbol and Q1.15 confidence in tdata.
// Thresholds are written through the csr_ port while the block is idle: a
// rule for the user; the block itself does not enforce it. One item is
// handled at a time under a small sequencer that drives one shared
// compare/subtract unit; req_tready is low while it works. Add reads and
// rewrites the counters. Predict: 1 table read, an 11-entry scan at one
// counter per cycle per level tried, and, unless the best count reaches the
// total, a 15-step restoring division. Clear sweeps the counter memories
// one entry a cycle. Reset (synchronous) starts the same clearing pass; no
// item is taken until it ends. A result waits in the output register while
// the receiver stalls; a later result is held until that one is taken.
`timescale 1ns / 1ps

module trigram_predictor_with_backoff
   import tgp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // first_symbol, second_symbol, third_symbol
   input  logic [FUNC_W-1:0]     req_tuser,  // func
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // predicted_symbol, confidence
   output logic [RSP_USER_W-1:0] rsp_tuser,  // found, level
   input  logic                  csr_we,
   input  logic [CSR_AW-1:0]     csr_addr,
   input  logic [THR_W-1:0]      csr_wdata
);

   typedef enum logic [10:0] {
      S_CLR      = 11'b000_0000_0001,
      S_IDLE     = 11'b000_0000_0010,
      S_ADD_RD   = 11'b000_0000_0100,
      S_ADD_WR   = 11'b000_0000_1000,
      S_P_RD     = 11'b000_0001_0000,
      S_P_CHK    = 11'b000_0010_0000,
      S_BACKOFF  = 11'b000_0100_0000,
      S_SCAN     = 11'b000_1000_0000,
      S_SCAN_END = 11'b001_0000_0000,
      S_DIV      = 11'b010_0000_0000,
      S_OUT      = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [THR_W-1:0]      min_triple_ff, min_pair_ff;
   logic [COUNT_BITS-1:0] single_ff [SYMBOLS];

   logic [TRI_AW-1:0]     clr_idx_ff, clr_idx_in;
   logic [TRI_AW-1:0]     tri_idx_ff, tri_idx_in;
   logic [PAIR_AW-1:0]    pair_idx_ff, pair_idx_in;
   logic [TRI_AW-1:0]     tri_base_ff, tri_base_in;
   logic [TRI_AW-1:0]     bk_base_ff, bk_base_in;
   logic [SYM_W-1:0]      b_ff, b_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic                  level_ff, level_in;
   logic [TRI_AW-1:0]     scan_base_ff, scan_base_in;
   logic [SCAN_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                  pend_ff, pend_in;
   logic [SYM_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [COUNT_BITS-1:0] best_ff, best_in;
   logic [SYM_W-1:0]      best_sym_ff, best_sym_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [CONF_W-1:0]     q_ff, q_in;
   logic [DIV_W-1:0]      div_cnt_ff, div_cnt_in;
   logic                  found_ff, found_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff, rsp_level_ff;
   logic [SYM_W-1:0]      rsp_sym_ff;
   logic [CONF_W-1:0]     rsp_conf_ff;

   logic [SYM_W-1:0]      sym_a, sym_b, sym_c;
   logic                  req_xfer, out_load, add_ok;
   logic [TRI_AW-1:0]     scan_addr;
   logic [COUNT_BITS-1:0] scan_n;

   logic                  tri_we, pair_we;
   logic [TRI_AW-1:0]     tri_wr_addr, tri_rd_addr;
   logic [PAIR_AW-1:0]    pair_wr_addr, pair_rd_addr;
   logic [COUNT_BITS-1:0] tri_wr_data, pair_wr_data, tri_rd_data, pair_rd_data;

   logic [OPW-1:0]        alu_x, alu_y;
   logic [OPW:0]          alu_diff;
   logic                  alu_ge;

   assign sym_a    = req_tdata[SYM_W-1:0];
   assign sym_b    = req_tdata[2*SYM_W-1:SYM_W];
   assign sym_c    = req_tdata[3*SYM_W-1:2*SYM_W];
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer = req_tvalid && req_tready;
   assign add_ok   = sym_ok(sym_a) && sym_ok(sym_b) && sym_ok(sym_c);
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
   assign scan_addr = scan_base_ff + TRI_AW'(scan_idx_ff);
   assign scan_n   = level_ff ? pair_rd_data : tri_rd_data;

   // shared compare/subtract unit
   always_comb begin
      alu_x = '0;
      alu_y = '0;
      unique case (state_ff)
         S_P_CHK: begin
            alu_x = OPW'(pair_rd_data);
            alu_y = OPW'(min_triple_ff);
         end
         S_BACKOFF: begin
            alu_x = OPW'(single_ff[b_ff]);
            alu_y = OPW'(min_pair_ff);
         end
         S_SCAN: begin
            alu_x = OPW'(best_ff);
            alu_y = OPW'(scan_n);
         end
         S_SCAN_END: begin
            alu_x = OPW'(best_ff);
            alu_y = OPW'(total_ff);
         end
         S_DIV: begin
            alu_x = OPW'({rem_ff, 1'b0});
            alu_y = OPW'(total_ff);
         end
         default: begin
            alu_x = '0;
            alu_y = '0;
         end
      endcase
   end

   assign alu_diff = {1'b0, alu_x} - {1'b0, alu_y};
   assign alu_ge   = !alu_diff[OPW];

   // memory ports
   always_comb begin
      tri_we       = 1'b0;
      pair_we      = 1'b0;
      tri_wr_addr  = tri_idx_ff;
      pair_wr_addr = pair_idx_ff;
      tri_wr_data  = sat_inc(tri_rd_data);
      pair_wr_data = sat_inc(pair_rd_data);
      tri_rd_addr  = (state_ff == S_SCAN) ? scan_addr : tri_idx_ff;
      pair_rd_addr = (state_ff == S_SCAN) ? scan_addr[PAIR_AW-1:0] : pair_idx_ff;
      if (state_ff == S_CLR) begin
         tri_we       = 1'b1;
         pair_we      = (int'(clr_idx_ff) < PAIR_DEPTH);
         tri_wr_addr  = clr_idx_ff;
         pair_wr_addr = clr_idx_ff[PAIR_AW-1:0];
         tri_wr_data  = '0;
         pair_wr_data = '0;
      end else if (state_ff == S_ADD_WR) begin
         tri_we  = 1'b1;
         pair_we = 1'b1;
      end
   end

   tgp_ram #(.WIDTH(COUNT_BITS), .DEPTH(TRI_DEPTH)) u_tri_ram (
      .clock   (clock),
      .wr_en   (tri_we),
      .wr_addr (tri_wr_addr),
      .wr_data (tri_wr_data),
      .rd_addr (tri_rd_addr),
      .rd_data (tri_rd_data)
   );

   tgp_ram #(.WIDTH(COUNT_BITS), .DEPTH(PAIR_DEPTH)) u_pair_ram (
      .clock   (clock),
      .wr_en   (pair_we),
      .wr_addr (pair_wr_addr),
      .wr_data (pair_wr_data),
      .rd_addr (pair_rd_addr),
      .rd_data (pair_rd_data)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      tri_idx_in   = tri_idx_ff;
      pair_idx_in  = pair_idx_ff;
      tri_base_in  = tri_base_ff;
      bk_base_in   = bk_base_ff;
      b_in         = b_ff;
      total_in     = total_ff;
      level_in     = level_ff;
      scan_base_in = scan_base_ff;
      scan_idx_in  = scan_idx_ff;
      pend_in      = pend_ff;
      cmp_idx_in   = cmp_idx_ff;
      best_in      = best_ff;
      best_sym_in  = best_sym_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      div_cnt_in   = div_cnt_ff;
      found_in     = found_ff;

      unique case (state_ff)
         S_CLR: begin
            clr_idx_in = clr_idx_ff + TRI_AW'(1);
            if (int'(clr_idx_ff) == TRI_DEPTH - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            pair_idx_in = PAIR_AW'(int'(sym_a) * SYMBOLS + int'(sym_b));
            tri_base_in = TRI_AW'((int'(sym_a) * SYMBOLS + int'(sym_b)) * SYMBOLS);
            tri_idx_in  = TRI_AW'((int'(sym_a) * SYMBOLS + int'(sym_b)) * SYMBOLS
                                  + int'(sym_c));
            bk_base_in  = TRI_AW'(int'(sym_b) * SYMBOLS);
            b_in        = sym_b;
            if (req_xfer) begin
               case (req_tuser)
                  FUNC_CLEAR: begin
                     clr_idx_in = '0;
                     state_in   = S_CLR;
                  end
                  FUNC_ADD: begin
                     if (add_ok) begin
                        state_in = S_ADD_RD;
                     end
                  end
                  FUNC_PREDICT: begin
                     if (sym_ok(sym_a) && sym_ok(sym_b)) begin
                        state_in = S_P_RD;
                     end else begin
                        found_in = 1'b0;
                        state_in = S_OUT;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ADD_RD: state_in = S_ADD_WR;
         S_ADD_WR: state_in = S_IDLE;
         S_P_RD:   state_in = S_P_CHK;
         S_P_CHK: begin
            total_in = pair_rd_data;
            if (alu_ge) begin
               level_in     = 1'b0;
               scan_base_in = tri_base_ff;
               scan_idx_in  = '0;
               pend_in      = 1'b0;
               best_in      = '0;
               best_sym_in  = '0;
               state_in     = S_SCAN;
            end else begin
               state_in = S_BACKOFF;
            end
         end
         S_BACKOFF: begin
            total_in = single_ff[b_ff];
            if (alu_ge) begin
               level_in     = 1'b1;
               scan_base_in = bk_base_ff;
               scan_idx_in  = '0;
               pend_in      = 1'b0;
               best_in      = '0;
               best_sym_in  = '0;
               state_in     = S_SCAN;
            end else begin
               found_in = 1'b0;
               state_in = S_OUT;
            end
         end
         S_SCAN: begin
            // read of entry k overlaps the compare of entry k-1
            pend_in    = (int'(scan_idx_ff) < SYMBOLS);
            cmp_idx_in = scan_idx_ff[SYM_W-1:0];
            if (int'(scan_idx_ff) < SYMBOLS) begin
               scan_idx_in = scan_idx_ff + SCAN_W'(1);
            end
            if (pend_ff && !alu_ge) begin
               best_in     = scan_n;
               best_sym_in = cmp_idx_ff;
            end
            if (pend_ff && int'(scan_idx_ff) == SYMBOLS) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            if (best_ff == '0) begin
               if (level_ff) begin
                  found_in = 1'b0;
                  state_in = S_OUT;
               end else begin
                  state_in = S_BACKOFF;
               end
            end else if (alu_ge) begin
               found_in = 1'b1;
               q_in     = Q_ONE;
               state_in = S_OUT;
            end else begin
               found_in   = 1'b1;
               rem_in     = best_ff;
               q_in       = '0;
               div_cnt_in = '0;
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            q_in       = {q_ff[CONF_W-2:0], alu_ge};
            rem_in     = alu_ge ? alu_diff[COUNT_BITS-1:0] : {rem_ff[COUNT_BITS-2:0], 1'b0};
            div_cnt_in = div_cnt_ff + DIV_W'(1);
            if (div_cnt_ff == DIV_W'(Q_FRAC - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLR;
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         clr_idx_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         min_triple_ff <= THR_W'(3);
         min_pair_ff   <= THR_W'(5);
         pend_ff       <= 1'b0;
         for (int i = 0; i < SYMBOLS; i++) begin
            single_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_MIN_TRIPLE: min_triple_ff <= csr_wdata;
               CSR_MIN_PAIR:   min_pair_ff   <= csr_wdata;
               default:        min_pair_ff   <= min_pair_ff;
            endcase
         end
         if (req_xfer && req_tuser == FUNC_CLEAR) begin
            for (int i = 0; i < SYMBOLS; i++) begin
               single_ff[i] <= '0;
            end
         end else if (req_xfer && req_tuser == FUNC_ADD && add_ok) begin
            single_ff[sym_a] <= sat_inc(single_ff[sym_a]);
         end
      end
   end

   always_ff @(posedge clock) begin
      tri_idx_ff   <= tri_idx_in;
      pair_idx_ff  <= pair_idx_in;
      tri_base_ff  <= tri_base_in;
      bk_base_ff   <= bk_base_in;
      b_ff         <= b_in;
      total_ff     <= total_in;
      level_ff     <= level_in;
      scan_base_ff <= scan_base_in;
      scan_idx_ff  <= scan_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_ff      <= best_in;
      best_sym_ff  <= best_sym_in;
      rem_ff       <= rem_in;
      q_ff         <= q_in;
      div_cnt_ff   <= div_cnt_in;
      found_ff     <= found_in;
      if (out_load) begin
         rsp_found_ff <= found_ff;
         rsp_level_ff <= found_ff && level_ff;
         rsp_sym_ff   <= found_ff ? best_sym_ff : '0;
         rsp_conf_ff  <= found_ff ? q_ff : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_conf_ff, rsp_sym_ff});
   assign rsp_tuser  = {rsp_level_ff, rsp_found_ff};

endmodule

### sv/tgp_checker.sv
// Port-level assertions for the trigram predictor, bound to the top level.
`timescale 1ns / 1ps

module tgp_checker
   import tgp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   // clearing pass follows reset: no transfer in either direction
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!req_tready && !rsp_tvalid))
      else $error("transfer possible straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed or dropped");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0 && !rsp_tuser[1]))
      else $error("result without prediction carries data");

   a_found_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         (int'(rsp_tdata[SYM_W-1:0]) < SYMBOLS && rsp_tdata[SYM_W +: CONF_W] <= Q_ONE))
      else $error("predicted symbol or confidence out of range");

endmodule

bind trigram_predictor_with_backoff tgp_checker u_tgp_checker (.*);

### verif/trigram_predictor_with_backoff_tb.sv
// Self-checking testbench for the trigram predictor with bigram back-off.
`timescale 1ns / 1ps

module trigram_predictor_with_backoff_tb;
   import tgp_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [THR_W-1:0]  RESET_MIN_TRIPLE = 16'd3;
   localparam logic [THR_W-1:0]  RESET_MIN_PAIR   = 16'd5;
   localparam int SYM_TOP      = (1 << SYM_W) - 1;
   localparam int CLEAR_CYCLES = 1400;
   localparam int BURST_ADDS   = 12;
   localparam int PHASE_QUOTA  = 250;
   localparam int CYCLE_LIMIT  = 2_000_000;

   typedef struct packed {
      logic              found;
      logic [SYM_W-1:0]  symbol;
      logic [CONF_W-1:0] confidence;
      logic              level;
   } prediction_type;

   class trigram_scoreboard_type;
      logic [COUNT_BITS-1:0] triple_cnt [TRI_DEPTH];
      logic [COUNT_BITS-1:0] pair_cnt [PAIR_DEPTH];
      logic [COUNT_BITS-1:0] first_cnt [SYMBOLS];
      logic [THR_W-1:0]      min_triple;
      logic [THR_W-1:0]      min_pair;
      prediction_type        pending [$];
      int                    fails;
      int                    checked;

      function new();
         wipe_counts();
         min_triple = RESET_MIN_TRIPLE;
         min_pair   = RESET_MIN_PAIR;
         fails      = 0;
         checked    = 0;
      endfunction

      function void wipe_counts();
         foreach (triple_cnt[i]) triple_cnt[i] = '0;
         foreach (pair_cnt[i]) pair_cnt[i] = '0;
         foreach (first_cnt[i]) first_cnt[i] = '0;
      endfunction

      function void set_threshold(input logic [CSR_AW-1:0] idx, input logic [THR_W-1:0] value);
         if (idx == CSR_MIN_TRIPLE) min_triple = value;
         else if (idx == CSR_MIN_PAIR) min_pair = value;
      endfunction

      function logic [CONF_W-1:0] q15_share(input logic [COUNT_BITS-1:0] part,
                                            input logic [COUNT_BITS-1:0] whole);
         longint unsigned q;
         if (whole == '0) return '0;
         q = (64'(part) << Q_FRAC) / 64'(whole);
         if (q > 64'(Q_ONE)) q = 64'(Q_ONE);
         return CONF_W'(q);
      endfunction

      function prediction_type predict_next(input logic [SYM_W-1:0] a,
                                            input logic [SYM_W-1:0] b);
         prediction_type        p;
         logic [COUNT_BITS-1:0] total;
         logic [COUNT_BITS-1:0] best_n;
         int                    base;
         p = '0;
         if (int'(a) >= SYMBOLS || int'(b) >= SYMBOLS) return p;
         total = pair_cnt[int'(a) * SYMBOLS + int'(b)];
         if (total >= min_triple) begin
            base   = (int'(a) * SYMBOLS + int'(b)) * SYMBOLS;
            best_n = '0;
            for (int s = 0; s < SYMBOLS; s++) begin
               if (triple_cnt[base + s] > best_n) begin
                  best_n   = triple_cnt[base + s];
                  p.symbol = SYM_W'(s);
               end
            end
            if (best_n != '0) begin
               p.found      = 1'b1;
               p.confidence = q15_share(best_n, total);
               return p;
            end
         end
         // back off to the bigram table on the second symbol
         p     = '0;
         total = first_cnt[int'(b)];
         if (total < min_pair) return p;
         base   = int'(b) * SYMBOLS;
         best_n = '0;
         for (int s = 0; s < SYMBOLS; s++) begin
            if (pair_cnt[base + s] > best_n) begin
               best_n   = pair_cnt[base + s];
               p.symbol = SYM_W'(s);
            end
         end
         if (best_n == '0) return '0;
         p.found      = 1'b1;
         p.level      = 1'b1;
         p.confidence = q15_share(best_n, total);
         return p;
      endfunction

      function void note_request(input logic [FUNC_W-1:0] f, input logic [SYM_W-1:0] a,
                                 input logic [SYM_W-1:0] b, input logic [SYM_W-1:0] c);
         int t;
         int pr;
         case (f)
            FUNC_CLEAR: wipe_counts();
            FUNC_ADD: begin
               if (int'(a) < SYMBOLS && int'(b) < SYMBOLS && int'(c) < SYMBOLS) begin
                  pr = int'(a) * SYMBOLS + int'(b);
                  t  = pr * SYMBOLS + int'(c);
                  if (triple_cnt[t] != CNT_MAX) triple_cnt[t] = triple_cnt[t] + 1'b1;
                  if (pair_cnt[pr] != CNT_MAX) pair_cnt[pr] = pair_cnt[pr] + 1'b1;
                  if (first_cnt[int'(a)] != CNT_MAX)
                     first_cnt[int'(a)] = first_cnt[int'(a)] + 1'b1;
               end
            end
            FUNC_PREDICT: pending = {pending, predict_next(a, b)};
            default: ;
         endcase
      endfunction

      task report_mismatch(input string what);
         fails++;
         if (fails <= 40) $display("MISMATCH at %0t ns: %s", $time, what);
      endtask

      task check_result(input logic [RSP_DATA_W-1:0] data, input logic [RSP_USER_W-1:0] user);
         prediction_type want;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result, data %h user %b", data, user));
            return;
         end
         want = pending.pop_front();
         checked++;
         if (user[0] !== want.found)
            report_mismatch($sformatf("result %0d found %b, want %b",
                                      checked, user[0], want.found));
         if (user[1] !== want.level)
            report_mismatch($sformatf("result %0d level %b, want %b",
                                      checked, user[1], want.level));
         if (data[SYM_W-1:0] !== want.symbol)
            report_mismatch($sformatf("result %0d symbol %0d, want %0d",
                                      checked, data[SYM_W-1:0], want.symbol));
         if (data[SYM_W +: CONF_W] !== want.confidence)
            report_mismatch($sformatf("result %0d confidence %0d, want %0d",
                                      checked, data[SYM_W +: CONF_W], want.confidence));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // first_symbol, second_symbol, third_symbol
   logic [FUNC_W-1:0]     req_tuser = '0;   // func
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // predicted_symbol, confidence
   logic [RSP_USER_W-1:0] rsp_tuser;        // found, level
   logic                  csr_we = 1'b0;
   logic [CSR_AW-1:0]     csr_addr = '0;
   logic [THR_W-1:0]      csr_wdata = '0;

   trigram_scoreboard_type board;
   bit                steady = 1'b0;
   int                cycle_count = 0;
   int                useful = 0;
   int                n_adds = 0;
   int                n_clears = 0;
   int                n_settings = 0;

   trigram_predictor_with_backoff u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycle_count, board.pending.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [SYM_W-1:0] rand_sym(input int hi);
      return SYM_W'($urandom_range(0, hi));
   endfunction

   function automatic logic [SYM_W-1:0] rand_any();
      return SYM_W'($urandom_range(0, SYM_TOP));
   endfunction

   function automatic logic [SYM_W-1:0] rand_bad();
      return SYM_W'($urandom_range(SYMBOLS, SYM_TOP));
   endfunction

   initial begin : rsp_side
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 20) hold = pick_gap();
         end
      end
   end

   task automatic send_item(input logic [FUNC_W-1:0] f, input logic [SYM_W-1:0] a,
                            input logic [SYM_W-1:0] b, input logic [SYM_W-1:0] c);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= REQ_DATA_W'({c, b, a});
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_request(f, a, b, c);
      if (f == FUNC_CLEAR) n_clears++;
      if (f == FUNC_ADD) n_adds++;
      if (f == FUNC_CLEAR || f == FUNC_PREDICT ||
          (f == FUNC_ADD && int'(a) < SYMBOLS && int'(b) < SYMBOLS && int'(c) < SYMBOLS))
         useful++;
   endtask

   // hold the sender off until every prediction is back, then idle for settle clocks so a clear can finish
   task automatic drain_block(input int settle);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_setting(input logic [THR_W-1:0] tri_min,
                                input logic [THR_W-1:0] pair_min);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_MIN_TRIPLE;
      csr_wdata <= tri_min;
      @(posedge clock);
      csr_addr  <= CSR_MIN_PAIR;
      csr_wdata <= pair_min;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_threshold(CSR_MIN_TRIPLE, tri_min);
      board.set_threshold(CSR_MIN_PAIR, pair_min);
      n_settings++;
   endtask

   task automatic run_phase(input logic [THR_W-1:0] tri_min, input logic [THR_W-1:0] pair_min,
                            input int hi, input bit wipe_first);
      logic [SYM_W-1:0] a;
      logic [SYM_W-1:0] b;
      logic [SYM_W-1:0] c;
      logic [SYM_W-1:0] seen_a [16];
      logic [SYM_W-1:0] seen_b [16];
      int               seen_n;
      int               r;
      int               k;
      int               target;
      drain_block(CLEAR_CYCLES);
      write_setting(tri_min, pair_min);
      if (wipe_first) send_item(FUNC_CLEAR, rand_any(), rand_any(), rand_any());
      seen_n = 0;
      target = useful + PHASE_QUOTA;
      while (useful < target) begin
         r = $urandom_range(0, 999);
         if (r < 4) drain_block(0);
         a = rand_sym(hi);
         b = rand_sym(hi);
         c = rand_sym(hi);
         if (r < 10) begin
            send_item(FUNC_CLEAR, rand_any(), rand_any(), rand_any());
         end else if (r < 35) begin
            send_item(FUNC_UNUSED, rand_any(), rand_any(), rand_any());
         end else if (r < 520) begin
            k = $urandom_range(0, 99);
            if (k < 3) a = rand_bad();
            else if (k < 6) b = rand_bad();
            else if (k < 9) c = rand_bad();
            else begin
               seen_a[seen_n % 16] = a;
               seen_b[seen_n % 16] = b;
               seen_n++;
            end
            send_item(FUNC_ADD, a, b, c);
         end else begin
            k = $urandom_range(0, 99);
            if (k < 75 && seen_n > 0) begin
               r = $urandom_range(0, ((seen_n < 16) ? seen_n : 16) - 1);
               if (k < 55) begin
                  a = seen_a[r];
                  b = seen_b[r];
               end else begin
                  b = seen_a[r];
               end
            end else if (k >= 88) begin
               a = rand_any();
               b = rand_any();
            end
            send_item(FUNC_PREDICT, a, b, rand_any());
         end
      end
   endtask

   initial begin : stimulus
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_item(FUNC_PREDICT, 4'd0, 4'd0, 4'd0);
      send_item(FUNC_PREDICT, SYM_W'(SYM_TOP), 4'd0, 4'd0);
      send_item(FUNC_PREDICT, 4'd0, SYM_W'(SYMBOLS), SYM_W'(SYM_TOP));
      repeat (3) send_item(FUNC_ADD, 4'd0, 4'd1, 4'd2);
      send_item(FUNC_PREDICT, 4'd0, 4'd1, 4'd0);
      send_item(FUNC_ADD, 4'd0, 4'd1, 4'd5);
      send_item(FUNC_PREDICT, 4'd0, 4'd1, 4'd0);
      repeat (2) send_item(FUNC_ADD, 4'd0, 4'd1, 4'd5);
      send_item(FUNC_PREDICT, 4'd0, 4'd1, 4'd0);          // tie, lower symbol wins
      send_item(FUNC_PREDICT, 4'd5, 4'd0, 4'd0);          // pair unseen, back-off on 0
      send_item(FUNC_ADD, SYM_W'(SYMBOLS), 4'd0, 4'd0);
      send_item(FUNC_ADD, 4'd0, SYM_W'(SYM_TOP), 4'd0);
      send_item(FUNC_ADD, 4'd0, 4'd0, SYM_W'(SYMBOLS + 1));
      send_item(FUNC_UNUSED, SYM_W'(SYM_TOP), SYM_W'(SYM_TOP), SYM_W'(SYM_TOP));
      send_item(FUNC_ADD, SYM_W'(SYMBOLS - 1), SYM_W'(SYMBOLS - 1), SYM_W'(SYMBOLS - 1));
      send_item(FUNC_PREDICT, SYM_W'(SYMBOLS - 1), SYM_W'(SYMBOLS - 1), 4'd0);
      send_item(FUNC_CLEAR, 4'd0, 4'd0, 4'd0);
      send_item(FUNC_PREDICT, 4'd0, 4'd1, 4'd0);

      // back-to-back burst with both thresholds at full scale, no idling
      drain_block(CLEAR_CYCLES);
      write_setting(CNT_MAX, CNT_MAX);
      steady = 1'b1;
      send_item(FUNC_CLEAR, 4'd0, 4'd0, 4'd0);
      repeat (BURST_ADDS) send_item(FUNC_ADD, 4'd4, 4'd7, 4'd9);
      send_item(FUNC_PREDICT, 4'd4, 4'd7, 4'd0);
      repeat (3) send_item(FUNC_ADD, 4'd4, 4'd7, 4'd9);
      send_item(FUNC_ADD, 4'd4, 4'd7, 4'd3);
      send_item(FUNC_PREDICT, 4'd4, 4'd7, 4'd0);
      send_item(FUNC_PREDICT, 4'd1, 4'd4, 4'd0);
      steady = 1'b0;

      run_phase(16'd0, 16'd0, 2, 1'b1);
      run_phase(16'd1, 16'd2, 4, 1'b1);
      run_phase(CNT_MAX, 16'd0, SYMBOLS - 1, 1'($urandom_range(0, 1)));
      run_phase(16'd0, CNT_MAX, SYMBOLS - 1, 1'b0);
      run_phase(THR_W'($urandom_range(0, 8)), THR_W'($urandom_range(0, 12)),
                $urandom_range(3, SYMBOLS - 1), 1'($urandom_range(0, 1)));
      run_phase(RESET_MIN_TRIPLE, RESET_MIN_PAIR, 5, 1'b1);

      drain_block(CLEAR_CYCLES);
      $display("Run covered %0d adds, %0d clears and %0d checked predictions over %0d settings",
               n_adds, n_clears, board.checked, n_settings);
      $display("of the thresholds, with a back-to-back burst and invalid symbols and codes.");
      if (board.fails == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
